@@ rtl/pdd_pkg.sv @@
// Shared types and constants for the Pelco-D response deframer.
// No dependencies; imported by every module of the block.
package pdd_pkg;

   // Frame kind codes reported with each completed frame
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ZOOM   = 2'd0;
   localparam kind_type KIND_FOCUS  = 2'd1;
   localparam kind_type KIND_OTHER  = 2'd2;
   localparam kind_type KIND_BADSUM = 2'd3;

   // Protocol bytes
   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] CMD_ZOOM  = 8'hA7;
   localparam logic [7:0] CMD_FOCUS = 8'h63;

   // View angle in centidegrees: ANGLE_WIDE at zoom 0, minus up to ANGLE_SPAN
   localparam int          ANGLE_W    = 13;
   localparam logic [12:0] ANGLE_WIDE = 13'd6370;
   localparam logic [12:0] ANGLE_SPAN = 13'd6140;

   // Widths of the scaled-angle arithmetic
   localparam int POS_W       = 16;
   localparam int PROD_W      = 29;   // ANGLE_SPAN * 16-bit zoom
   localparam int RECIP_SHIFT = 29;   // fixed-point shift of the reciprocal
   localparam int RECIP_W     = 30;   // holds 2^RECIP_SHIFT / 1

   // Completed frame handed from the deframer to the angle pipeline
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         address;
      logic [POS_W-1:0]   position;
      logic               changed;
      logic [POS_W-1:0]   zoom;
   } frame_type;

endpackage

@@ rtl/pelco_d_response_deframer.sv @@
// Top level of the Pelco-D response deframer: byte collector and angle pipeline.
// Depends on pdd_pkg, pdd_framer and pdd_angle.
//
//   channel | direction | handshake          | word
//   req_    | in        | req_valid/req_stall | one received serial byte
//   rsp_    | out       | rsp_valid/rsp_stall | one completed-frame report
//
// One byte is taken per cycle while req_stall is low; bytes that do not end a frame cause no result.
// A frame report passes through the four-stage angle pipeline (span multiply,
// reciprocal multiply, check, hold), whose first stage loads at the edge that
// takes its checksum byte.
// Reset is synchronous and clears the frame phase, sums, stored positions and
// all pipeline valids. A stall on rsp_ backs up the pipeline; req_stall rises
// only once the first pipeline stage is full and cannot move.
module pelco_d_response_deframer
   import pdd_pkg::*;
#(
   parameter int ZOOM_FULL_SCALE = 16384
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_frame_kind,
   output logic [7:0]          rsp_device_address,
   output logic [POS_W-1:0]    rsp_position,
   output logic [ANGLE_W-1:0]  rsp_view_angle,
   output logic                rsp_value_changed
);

   logic      byte_accept;
   logic      frame_done;
   logic      pipe_ready;
   frame_type frame;

   assign req_stall   = !pipe_ready;
   assign byte_accept = req_valid && pipe_ready;

   pdd_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .frame_done  (frame_done),
      .frame       (frame)
   );

   pdd_angle #(
      .ZOOM_FULL_SCALE (ZOOM_FULL_SCALE)
   ) u_angle (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (frame_done),
      .frame              (frame),
      .in_ready           (pipe_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_kind     (rsp_frame_kind),
      .rsp_device_address (rsp_device_address),
      .rsp_position       (rsp_position),
      .rsp_view_angle     (rsp_view_angle),
      .rsp_value_changed  (rsp_value_changed)
   );

endmodule

@@ rtl/pdd_framer.sv @@
// Byte-level frame collector: sync hunt, field capture, checksum and stored positions.
// Depends on pdd_pkg.
module pdd_framer
   import pdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_accept,
   input  logic [7:0]  rx_byte,
   output logic        frame_done,
   output frame_type   frame
);

   // Frame byte phases
   localparam logic [2:0] PHASE_HUNT = 3'd0;
   localparam logic [2:0] PHASE_ADDR = 3'd1;
   localparam logic [2:0] PHASE_CMD1 = 3'd2;
   localparam logic [2:0] PHASE_CMD2 = 3'd3;
   localparam logic [2:0] PHASE_DHI  = 3'd4;
   localparam logic [2:0] PHASE_DLO  = 3'd5;
   localparam logic [2:0] PHASE_SUM  = 3'd6;

   logic [2:0]       phase_ff,   phase_in;
   logic [7:0]       sum_ff,     sum_in;
   logic [7:0]       addr_ff,    addr_in;
   logic [7:0]       cmd2_ff,    cmd2_in;
   logic [7:0]       dhi_ff,     dhi_in;
   logic [7:0]       dlo_ff,     dlo_in;
   logic [POS_W-1:0] zoom_ff,    zoom_in;
   logic [POS_W-1:0] focus_ff,   focus_in;
   logic [POS_W-1:0] pos;

   assign pos = {dhi_ff, dlo_ff};

   // Advance the phase, capture fields and settle the frame on its checksum word
   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      addr_in    = addr_ff;
      cmd2_in    = cmd2_ff;
      dhi_in     = dhi_ff;
      dlo_in     = dlo_ff;
      zoom_in    = zoom_ff;
      focus_in   = focus_ff;
      frame_done = 1'b0;
      frame.kind     = KIND_OTHER;
      frame.address  = addr_ff;
      frame.position = pos;
      frame.changed  = 1'b0;
      frame.zoom     = zoom_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            PHASE_ADDR, PHASE_CMD1, PHASE_CMD2, PHASE_DHI, PHASE_DLO: begin
               if (phase_ff == PHASE_ADDR) addr_in = rx_byte;
               if (phase_ff == PHASE_CMD2) cmd2_in = rx_byte;
               if (phase_ff == PHASE_DHI)  dhi_in  = rx_byte;
               if (phase_ff == PHASE_DLO)  dlo_in  = rx_byte;
               sum_in   = sum_ff + rx_byte;
               phase_in = phase_ff + 3'd1;
            end
            PHASE_SUM: begin
               phase_in   = PHASE_HUNT;
               sum_in     = 8'd0;
               frame_done = 1'b1;
               priority if (rx_byte != sum_ff) begin
                  frame.kind = KIND_BADSUM;
               end else if (cmd2_ff == CMD_ZOOM) begin
                  frame.kind    = KIND_ZOOM;
                  frame.changed = (zoom_ff != pos);
                  frame.zoom    = pos;
                  zoom_in       = pos;
               end else if (cmd2_ff == CMD_FOCUS) begin
                  frame.kind    = KIND_FOCUS;
                  frame.changed = (focus_ff != pos);
                  focus_in      = pos;
               end else begin
                  frame.kind = KIND_OTHER;
               end
            end
            default: begin
               // hunting, and the unreachable phase code
               phase_in = (rx_byte == SYNC_BYTE) ? PHASE_ADDR : PHASE_HUNT;
               sum_in   = 8'd0;
            end
         endcase
      end
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         sum_ff   <= 8'd0;
         addr_ff  <= 8'd0;
         cmd2_ff  <= 8'd0;
         dhi_ff   <= 8'd0;
         dlo_ff   <= 8'd0;
         zoom_ff  <= '0;
         focus_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         addr_ff  <= addr_in;
         cmd2_ff  <= cmd2_in;
         dhi_ff   <= dhi_in;
         dlo_ff   <= dlo_in;
         zoom_ff  <= zoom_in;
         focus_ff <= focus_in;
      end
   end

endmodule

@@ rtl/pdd_angle.sv @@
// Result pipeline: scales the stored zoom to a view angle and holds the result word.
// Depends on pdd_pkg.
module pdd_angle
   import pdd_pkg::*;
#(
   parameter int ZOOM_FULL_SCALE = 16384
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  frame_type           frame,
   output logic                in_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_frame_kind,
   output logic [7:0]          rsp_device_address,
   output logic [POS_W-1:0]    rsp_position,
   output logic [ANGLE_W-1:0]  rsp_view_angle,
   output logic                rsp_value_changed
);

   localparam int                   FULL_W = PROD_W + RECIP_W;
   localparam logic [POS_W-1:0]     SCALE  = POS_W'(ZOOM_FULL_SCALE);
   localparam logic [RECIP_W-1:0]   RECIP  =
      RECIP_W'((64'd1 << RECIP_SHIFT) / ZOOM_FULL_SCALE);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   frame_type            fr1_ff, fr2_ff, fr3_ff, fr4_ff;
   logic [PROD_W-1:0]    p1_ff, p2_ff, p3_ff;
   logic [ANGLE_W-1:0]   q2_ff, q3_ff;
   logic [PROD_W-1:0]    back3_ff;
   logic [ANGLE_W-1:0]   angle4_ff;

   logic [POS_W-1:0]     zc;
   logic [FULL_W-1:0]    est_full;
   logic                 fix;
   logic [ANGLE_W-1:0]   q_final;

   // Each stage moves when the one after it is empty or moving
   assign rdy4     = !v4_ff || !rsp_stall;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Clamp zoom to full scale and estimate the quotient by reciprocal multiply
   assign zc       = (frame.zoom > SCALE) ? SCALE : frame.zoom;
   assign est_full = FULL_W'(p1_ff) * FULL_W'(RECIP);
   // Estimate is at most one short; correct with one compare
   assign fix      = (p3_ff - back3_ff) >= PROD_W'(SCALE);
   assign q_final  = q3_ff + ANGLE_W'(fix);

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (rdy1) begin
         fr1_ff <= frame;
         p1_ff  <= PROD_W'(ANGLE_SPAN) * PROD_W'(zc);
      end
      if (rdy2) begin
         fr2_ff <= fr1_ff;
         p2_ff  <= p1_ff;
         q2_ff  <= est_full[RECIP_SHIFT +: ANGLE_W];
      end
      if (rdy3) begin
         fr3_ff   <= fr2_ff;
         p3_ff    <= p2_ff;
         q3_ff    <= q2_ff;
         back3_ff <= PROD_W'(q2_ff) * PROD_W'(SCALE);
      end
      if (rdy4) begin
         fr4_ff    <= fr3_ff;
         angle4_ff <= ANGLE_WIDE - q_final;
      end
   end

   assign rsp_valid          = v4_ff;
   assign rsp_frame_kind     = fr4_ff.kind;
   assign rsp_device_address = fr4_ff.address;
   assign rsp_position       = fr4_ff.position;
   assign rsp_value_changed  = fr4_ff.changed;
   assign rsp_view_angle     = angle4_ff;

endmodule

@@ rtl/pdd_checker.sv @@
// Port-level checks for the Pelco-D response deframer, bound to the top level.
// Depends on pdd_pkg and pelco_d_response_deframer.
module pdd_checker
   import pdd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [1:0]          rsp_frame_kind,
   input  logic [7:0]          rsp_device_address,
   input  logic [POS_W-1:0]    rsp_position,
   input  logic [ANGLE_W-1:0]  rsp_view_angle,
   input  logic                rsp_value_changed
);

   // Hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_kind)
         && $stable(rsp_device_address) && $stable(rsp_position)
         && $stable(rsp_view_angle) && $stable(rsp_value_changed))
      else $error("stalled result word changed");

   // Only zoom and focus reports can flag a changed position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_kind == KIND_OTHER || rsp_frame_kind == KIND_BADSUM)
         |-> !rsp_value_changed)
      else $error("value_changed set on a non-position report");

   // View angle stays between the full-scale and zero-zoom limits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_view_angle >= 13'd230 && rsp_view_angle <= ANGLE_WIDE)
      else $error("view angle out of range");

   // No result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind pelco_d_response_deframer pdd_checker u_pdd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_frame_kind     (rsp_frame_kind),
   .rsp_device_address (rsp_device_address),
   .rsp_position       (rsp_position),
   .rsp_view_angle     (rsp_view_angle),
   .rsp_value_changed  (rsp_value_changed)
);

@@ sim/pelco_d_response_deframer_test.sv @@
// Self-checking testbench for pelco_d_response_deframer: byte stream in, frame reports out.
// Depends on pdd_pkg and the RTL of the block; a scoreboard class predicts each report.
module pelco_d_response_deframer_test;
   import pdd_pkg::*;

   localparam int ZOOM_FULL_SCALE = 16384;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RANDOM_BYTES    = 1850;

   // Frame byte counter: hunting, then the next byte expected in the frame
   localparam logic [2:0] PHASE_HUNT     = 3'd0;
   localparam logic [2:0] PHASE_ADDRESS  = 3'd1;
   localparam logic [2:0] PHASE_CMD_TWO  = 3'd3;
   localparam logic [2:0] PHASE_DATA_HI  = 3'd4;
   localparam logic [2:0] PHASE_DATA_LO  = 3'd5;
   localparam logic [2:0] PHASE_CHECKSUM = 3'd6;

   typedef struct packed {
      kind_type            kind;
      logic [7:0]          address;
      logic [POS_W-1:0]    position;
      logic [ANGLE_W-1:0]  angle;
      logic                changed;
   } report_type;

   class frame_scoreboard;
      logic [2:0]        phase;
      logic [7:0]        sum;
      logic [7:0]        address;
      logic [7:0]        cmd_two;
      logic [7:0]        data_hi;
      logic [7:0]        data_lo;
      logic [POS_W-1:0]  zoom;
      logic [POS_W-1:0]  focus;
      report_type        pending[$];
      int                errors;

      function new();
         phase = PHASE_HUNT;
         sum = '0;
         address = '0;
         cmd_two = '0;
         data_hi = '0;
         data_lo = '0;
         zoom = '0;
         focus = '0;
         errors = 0;
      endfunction

      // Angle narrows linearly with zoom, clipped at full scale
      function logic [ANGLE_W-1:0] angle_of(logic [POS_W-1:0] z);
         int unsigned clipped;
         int unsigned narrowed;
         clipped = (z > ZOOM_FULL_SCALE) ? ZOOM_FULL_SCALE : z;
         narrowed = (int'(ANGLE_SPAN) * clipped) / ZOOM_FULL_SCALE;
         return ANGLE_WIDE - ANGLE_W'(narrowed);
      endfunction

      // Advance the frame state by one accepted word; queue a report on the checksum
      function void note_byte(logic [7:0] b);
         report_type r;
         logic [POS_W-1:0] pos;
         if (phase == PHASE_HUNT || phase > PHASE_CHECKSUM) begin
            phase = (b == SYNC_BYTE) ? PHASE_ADDRESS : PHASE_HUNT;
            sum = '0;
            return;
         end
         if (phase < PHASE_CHECKSUM) begin
            case (phase)
               PHASE_ADDRESS: address = b;
               PHASE_CMD_TWO: cmd_two = b;
               PHASE_DATA_HI: data_hi = b;
               PHASE_DATA_LO: data_lo = b;
               default: ;
            endcase
            sum = sum + b;
            phase = phase + 3'd1;
            return;
         end
         phase = PHASE_HUNT;
         pos = {data_hi, data_lo};
         r.changed = 1'b0;
         if (b != sum) begin
            r.kind = KIND_BADSUM;
         end else if (cmd_two == CMD_ZOOM) begin
            r.kind = KIND_ZOOM;
            r.changed = (zoom != pos);
            zoom = pos;
         end else if (cmd_two == CMD_FOCUS) begin
            r.kind = KIND_FOCUS;
            r.changed = (focus != pos);
            focus = pos;
         end else begin
            r.kind = KIND_OTHER;
         end
         sum = '0;
         r.address = address;
         r.position = pos;
         r.angle = angle_of(zoom);
         pending.push_back(r);
      endfunction

      task report(string what);
         $display("MISMATCH: %s", what);
         errors++;
      endtask

      // Compare one accepted report against the oldest prediction
      task check_result(report_type got);
         report_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected report kind %0d address %02h position %04h",
                             got.kind, got.address, got.position));
            return;
         end
         want = pending.pop_front();
         if (got !== want)
            report($sformatf({"got kind %0d addr %02h pos %04h angle %0d chg %0b, ",
                              "want kind %0d addr %02h pos %04h angle %0d chg %0b"},
                             got.kind, got.address, got.position, got.angle, got.changed,
                             want.kind, want.address, want.position, want.angle,
                             want.changed));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_rx_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_frame_kind;
   logic [7:0]          rsp_device_address;
   logic [POS_W-1:0]    rsp_position;
   logic [ANGLE_W-1:0]  rsp_view_angle;
   logic                rsp_value_changed;

   frame_scoreboard     board;
   int                  cycles = 0;
   int                  frame_bytes = 0;
   bit                  req_quiet = 1'b0;
   bit                  rsp_quiet = 1'b0;
   logic [POS_W-1:0]    last_data = '0;

   pelco_d_response_deframer #(
      .ZOOM_FULL_SCALE(ZOOM_FULL_SCALE)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_kind(rsp_frame_kind),
      .rsp_device_address(rsp_device_address),
      .rsp_position(rsp_position),
      .rsp_view_angle(rsp_view_angle),
      .rsp_value_changed(rsp_value_changed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("pelco_d_response_deframer test failed");
         $finish;
      end
   end

   // Offer one word after a random gap and hold it until taken
   task send_byte(input logic [7:0] b);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(b);
   endtask

   // Send sync, five middle words and a checksum, good or corrupted
   task send_frame(input logic [7:0] addr, input logic [7:0] cmd_a, input logic [7:0] cmd_b,
                   input logic [POS_W-1:0] data, input bit good_sum);
      logic [7:0] check;
      check = addr + cmd_a + cmd_b + data[15:8] + data[7:0];
      if (!good_sum)
         check = check ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 9) == 0)
         req_quiet = !req_quiet;
      send_byte(SYNC_BYTE);
      send_byte(addr);
      send_byte(cmd_a);
      send_byte(cmd_b);
      send_byte(data[15:8]);
      send_byte(data[7:0]);
      send_byte(check);
      frame_bytes += 7;
   endtask

   // Bias positions toward the ends, the clip point and repeats
   function logic [POS_W-1:0] pick_data();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'(ZOOM_FULL_SCALE - 2 + $urandom_range(0, 4));
         3: return last_data;
         default: return 16'($urandom);
      endcase
   endfunction

   function logic [7:0] pick_command();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7: return CMD_ZOOM;
         8, 9, 10, 11, 12, 13, 14: return CMD_FOCUS;
         default: return 8'($urandom);
      endcase
   endfunction

   // Stimulus
   initial begin
      int noise;
      logic [POS_W-1:0] data;
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Hunting drops non-sync words
      send_byte(8'h00);
      send_byte(8'h55);
      // Sync words inside the frame, all-ones address and position, clipped angle
      send_frame(8'hFF, 8'h00, CMD_ZOOM, 16'hFFFF, 1'b1);
      // Focus write of the stored value leaves it unchanged
      send_frame(8'h00, 8'h00, CMD_FOCUS, 16'h0000, 1'b1);
      // Corrupted checksum on an unknown command
      send_frame(8'h12, 8'h80, 8'h5A, 16'h3456, 1'b0);

      frame_bytes = 0;
      while (frame_bytes < RANDOM_BYTES) begin
         noise = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
         repeat (noise) send_byte(8'($urandom));
         frame_bytes += noise;
         data = pick_data();
         send_frame(($urandom_range(0, 15) == 0) ? SYNC_BYTE : 8'($urandom),
                    8'($urandom), pick_command(), data, $urandom_range(0, 9) != 0);
         last_data = data;
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("pelco_d_response_deframer test passed");
      else
         $display("pelco_d_response_deframer test failed");
      $finish;
   end

   // Result side: random stall before each word, then check it
   initial begin
      int hold;
      report_type got;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0)
            rsp_quiet = !rsp_quiet;
         hold = rsp_quiet ? 0 : $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got.kind = rsp_frame_kind;
         got.address = rsp_device_address;
         got.position = rsp_position;
         got.angle = rsp_view_angle;
         got.changed = rsp_value_changed;
         board.check_result(got);
      end
   end

endmodule

@@ pelco_d_response_deframer.f @@
rtl/pdd_pkg.sv
rtl/pdd_framer.sv
rtl/pdd_angle.sv
rtl/pelco_d_response_deframer.sv
rtl/pdd_checker.sv
sim/pelco_d_response_deframer_test.sv
